/* src/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MaxLevels = 12;
	localparam int SizeWidth = 32;
	localparam int NodeW = MaxLevels;
	localparam int MapDepth = 1 << MaxLevels;
	localparam int LvlW = 4;
	localparam logic [SizeWidth-1:0] HeaderBytes = SizeWidth'(4);
	localparam logic [31:0] ArenaReset = 32'd1048576;
	localparam logic [3:0] LevelsReset = 4'd8;

	localparam logic CfgArena = 1'b0;
	localparam logic CfgLevels = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_BAD_INDEX = 3'd4,
		ST_NOT_USED  = 3'd5
	} status_t;

	localparam logic OpAlloc = 1'b0;
	localparam logic OpFree = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic clr_step;  // clearing pass: clear one map entry
		logic rd;        // issue map read at current node
		logic go_left;   // descend to the left child
		logic go_right;  // move to the right sibling
		logic go_up;     // climb to the parent
		logic mark_split;
		logic mark_used;
		logic clr_used;
		logic clr_split_parent;
		logic lvl_step;  // decrement wanted level
		logic offs_calc; // register the offset product
		logic fin;       // load the result register
		status_t fin_status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic op_free;
		logic req_zero;
		logic too_large;
		logic lvl_fits;   // block at wanted level holds the request
		logic at_want;    // current level equals wanted level
		logic beyond_top; // current node above the top node
		logic node_used;
		logic node_split;
		logic buddy_free;
		logic is_root;
		logic is_left;    // current node is a left child
		logic idx_bad;
	} dp_stat_t;

endpackage

/* src/bitmap_buddy_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap buddy allocator
// Binary buddy allocator over a split map and a used map of 4096 bits each.
// ----------------------------------------------------------------------------
// After reset a clearing pass clears all 4096 entries of both maps, one map
// entry a cycle, before the block takes its first item; configuration writes
// are taken only while no item is in work and the clearing pass is over. An
// allocate transfer checks the request, steps the wanted level down until a
// block at that level holds it, then runs a depth-first search that reads
// the maps at each node it visits and steps back up the tree where a subtree
// has no room. A free transfer checks the index and the used bit, then climbs
// the tree, merging while the buddy is free. One item is in work at a time;
// while a result waits in the result register the next item is accepted
// only in the cycle in which that result is taken.
module bitmap_buddy_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] request_bytes,
	input  logic [11:0] node_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [11:0] granted_node,
	output logic [3:0]  granted_level,
	output logic [31:0] byte_offset
);

	bba_pkg::dp_cmd_t  cmd;
	bba_pkg::dp_stat_t stat;
	logic [31:0] arena_q;
	logic [3:0]  levels_q;
	logic        busy;

	// Configuration registers are writable whenever the controller is idle.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q  <= bba_pkg::ArenaReset;
			levels_q <= bba_pkg::LevelsReset;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == bba_pkg::CfgArena)
				arena_q <= cfg_data;
			else
				levels_q <= cfg_data[3:0];
		end
	end

	bba_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.busy, .cmd, .stat
	);

	bba_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.arena_cfg (arena_q),
		.levels_cfg(levels_q),
		.operation, .request_bytes, .node_index,
		.status, .granted_node, .granted_level, .byte_offset
	);

endmodule

/* src/bba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Holds the two bit maps, the tree walk registers and the result register.
// ----------------------------------------------------------------------------
module bba_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bba_pkg::dp_cmd_t                cmd,
	output bba_pkg::dp_stat_t               stat,
	input  logic [31:0]                     arena_cfg,
	input  logic [3:0]                      levels_cfg,
	input  logic                            operation,
	input  logic [31:0]                     request_bytes,
	input  logic [11:0]                     node_index,
	output logic [2:0]                      status,
	output logic [11:0]                     granted_node,
	output logic [3:0]                      granted_level,
	output logic [31:0]                     byte_offset
);

	logic [bba_pkg::NodeW:0]        node_q;   // one extra bit for the right edge
	logic [bba_pkg::LvlW-1:0]       lvl_q;
	logic [bba_pkg::LvlW-1:0]       want_q;
	logic                           op_q;
	logic [bba_pkg::SizeWidth:0]    need_q;
	logic [bba_pkg::SizeWidth-1:0]  arena_q;
	logic                           req_zero_q;
	logic [bba_pkg::NodeW-1:0]      idx_q;
	logic [bba_pkg::NodeW:0]        clr_cnt_q;
	logic [bba_pkg::SizeWidth-1:0]  offs_q;

	logic split_mem [bba_pkg::MapDepth];
	logic used_mem  [bba_pkg::MapDepth];
	logic split_rd_q, used_rd_q, bsplit_rd_q, bused_rd_q;

	logic [bba_pkg::LvlW-1:0]    eff_lvls;
	logic [bba_pkg::NodeW:0]     top_node;
	logic [bba_pkg::NodeW-1:0]   addr;
	logic [bba_pkg::NodeW-1:0]   buddy;
	logic [bba_pkg::NodeW-1:0]   parent;
	logic [bba_pkg::NodeW-1:0]   rel;

	always_comb begin
		eff_lvls = levels_cfg;
		if (levels_cfg == '0)
			eff_lvls = bba_pkg::LvlW'(1);
		if (levels_cfg > bba_pkg::LvlW'(bba_pkg::MaxLevels - 1))
			eff_lvls = bba_pkg::LvlW'(bba_pkg::MaxLevels - 1);
		top_node = ((bba_pkg::NodeW+1)'(1) << (eff_lvls + 1'b1)) - 1'b1;
		addr = node_q[bba_pkg::NodeW-1:0];
		buddy = addr ^ bba_pkg::NodeW'(1);
		parent = addr >> 1;
		rel = addr & ~(bba_pkg::NodeW'(1) << lvl_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Map memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			split_mem[clr_cnt_q[bba_pkg::NodeW-1:0]] <= 1'b0;
			used_mem[clr_cnt_q[bba_pkg::NodeW-1:0]]  <= 1'b0;
		end else begin
			if (cmd.mark_split)
				split_mem[addr] <= 1'b1;
			else if (cmd.clr_split_parent)
				split_mem[parent] <= 1'b0;
			if (cmd.mark_used)
				used_mem[addr] <= 1'b1;
			else if (cmd.clr_used)
				used_mem[addr] <= 1'b0;
		end
		if (cmd.rd) begin
			split_rd_q  <= split_mem[addr];
			used_rd_q   <= used_mem[addr];
			bsplit_rd_q <= split_mem[buddy];
			bused_rd_q  <= used_mem[buddy];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			lvl_q  <= '0;
		end else if (cmd.load) begin
			node_q <= operation ? (bba_pkg::NodeW+1)'(node_index)
			                    : (bba_pkg::NodeW+1)'(1);
			lvl_q  <= '0;
		end else if (cmd.go_left) begin
			node_q <= {node_q[bba_pkg::NodeW-1:0], 1'b0};
			lvl_q  <= lvl_q + 1'b1;
		end else if (cmd.go_right) begin
			node_q <= node_q + 1'b1;
		end else if (cmd.go_up) begin
			node_q <= node_q >> 1;
			lvl_q  <= lvl_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= operation;
			arena_q    <= bba_pkg::SizeWidth'(arena_cfg);
			need_q     <= (bba_pkg::SizeWidth+1)'(request_bytes) +
			              (bba_pkg::SizeWidth+1)'(bba_pkg::HeaderBytes);
			req_zero_q <= (request_bytes == '0);
			idx_q      <= node_index;
			want_q     <= eff_lvls;
		end else if (cmd.lvl_step) begin
			want_q <= want_q - 1'b1;
		end
		if (cmd.offs_calc)
			offs_q <= bba_pkg::SizeWidth'(rel * (arena_q >> lvl_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status <= cmd.fin_status;
			if (cmd.fin_status == bba_pkg::ST_OK && !op_q) begin
				granted_node  <= addr;
				granted_level <= lvl_q;
				byte_offset   <= offs_q;
			end else begin
				granted_node  <= '0;
				granted_level <= '0;
				byte_offset   <= '0;
			end
		end
	end

	always_comb begin
		stat.clr_done   = clr_cnt_q[bba_pkg::NodeW];
		stat.op_free    = op_q;
		stat.req_zero   = req_zero_q;
		stat.too_large  = need_q > (bba_pkg::SizeWidth+1)'(arena_q);
		stat.lvl_fits   = (bba_pkg::SizeWidth+1)'(arena_q >> want_q) >= need_q;
		stat.at_want    = lvl_q == want_q;
		stat.beyond_top = node_q > top_node;
		stat.node_used  = used_rd_q;
		stat.node_split = split_rd_q;
		stat.buddy_free = !bsplit_rd_q && !bused_rd_q;
		stat.is_root    = node_q == (bba_pkg::NodeW+1)'(1);
		stat.is_left    = !node_q[0];
		stat.idx_bad    = idx_q == '0 || (bba_pkg::NodeW+1)'(idx_q) > top_node;
	end

endmodule

/* src/bba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the clearing pass, the depth-first search and the merge climb.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              busy,
	output bba_pkg::dp_cmd_t  cmd,
	input  bba_pkg::dp_stat_t stat
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_CHECK  = 13'b0000000000100,
		S_FIT    = 13'b0000000001000,
		S_RD     = 13'b0000000010000,
		S_VISIT  = 13'b0000000100000,
		S_BACK   = 13'b0000001000000,
		S_OFFS   = 13'b0000010000000,
		S_DONE   = 13'b0000100000000,
		S_FRD    = 13'b0001000000000,
		S_FCHK   = 13'b0010000000000,
		S_MERGE  = 13'b0100000000000,
		S_MRD    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   emit;

	// The result register frees up as soon as its transfer completes.
	assign emit      = cmd.fin;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign busy      = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.fin_status = bba_pkg::ST_OK;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_done)
					state_d = S_IDLE;
				else
					cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.op_free) begin
					if (stat.idx_bad) begin
						cmd.fin = 1'b1;
						cmd.fin_status = bba_pkg::ST_BAD_INDEX;
						state_d = S_IDLE;
					end else begin
						state_d = S_FRD;
					end
				end else if (stat.req_zero) begin
					cmd.fin = 1'b1;
					cmd.fin_status = bba_pkg::ST_ZERO;
					state_d = S_IDLE;
				end else if (stat.too_large) begin
					cmd.fin = 1'b1;
					cmd.fin_status = bba_pkg::ST_TOO_LARGE;
					state_d = S_IDLE;
				end else begin
					state_d = S_FIT;
				end
			end
			S_FIT: begin
				if (stat.lvl_fits || stat.at_want)
					state_d = S_RD;
				else
					cmd.lvl_step = 1'b1;
			end
			S_RD: begin
				if (stat.beyond_top) begin
					state_d = S_BACK;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_VISIT;
				end
			end
			S_VISIT: begin
				if (stat.node_used) begin
					state_d = S_BACK;
				end else if (stat.at_want) begin
					if (!stat.node_split) begin
						cmd.mark_used = 1'b1;
						state_d = S_OFFS;
					end else begin
						state_d = S_BACK;
					end
				end else begin
					if (!stat.node_split)
						cmd.mark_split = 1'b1;
					cmd.go_left = 1'b1;
					state_d = S_RD;
				end
			end
			S_BACK: begin
				// Root failed: no space. Left child failed: try its sibling. Right child failed: pop.
				if (stat.is_root) begin
					cmd.fin = 1'b1;
					cmd.fin_status = bba_pkg::ST_NO_SPACE;
					state_d = S_IDLE;
				end else if (stat.is_left) begin
					cmd.go_right = 1'b1;
					state_d = S_RD;
				end else begin
					cmd.go_up = 1'b1;
				end
			end
			S_OFFS: begin
				cmd.offs_calc = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.fin = 1'b1;
				cmd.fin_status = bba_pkg::ST_OK;
				state_d = S_IDLE;
			end
			S_FRD: begin
				cmd.rd = 1'b1;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (!stat.node_used) begin
					cmd.fin = 1'b1;
					cmd.fin_status = bba_pkg::ST_NOT_USED;
					state_d = S_IDLE;
				end else begin
					cmd.clr_used = 1'b1;
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				// A used node is never split, and every node reached by the climb
				// has just had its split bit cleared, so only the buddy decides.
				if (stat.is_root || !stat.buddy_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.clr_split_parent = 1'b1;
					cmd.go_up = 1'b1;
					state_d = S_MRD;
				end
			end
			S_MRD: begin
				cmd.rd = 1'b1;
				state_d = S_MERGE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_load_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CHECK)
		else $error("load not followed by check");
	a_no_clear_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready)
		else $error("ready during clearing");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap buddy allocator testbench
// Drives allocate and free transfers against an in-bench model of the
// split and used maps, then checks every result transfer field by field.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [31:0] request_bytes;
	logic [11:0] node_index;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [11:0] granted_node;
	logic [3:0]  granted_level;
	logic [31:0] byte_offset;

	bitmap_buddy_allocator u_top (.*);

	// One expected result transfer.
	typedef struct {
		bba_pkg::status_t st;
		logic [11:0]      node;
		logic [3:0]       lvl;
		logic [31:0]      offs;
	} grant_t;

	grant_t      grant_q[$];
	logic [11:0] held_nodes[$];

	// Model state: both maps and the two registers as the block holds them.
	logic        split_bits[bba_pkg::MapDepth];
	logic        used_bits[bba_pkg::MapDepth];
	logic [31:0] arena_reg;
	logic [3:0]  levels_reg;

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int burst_left = 0;
	int stall_mode = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TIMEOUT at %0t", $time);
		$display("bitmap_buddy_allocator verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Model of the allocator.
	// ------------------------------------------------------------------
	function automatic int eff_levels();
		int l;
		l = levels_reg;
		if (l < 1) l = 1;
		if (l > bba_pkg::MaxLevels - 1) l = bba_pkg::MaxLevels - 1;
		return l;
	endfunction

	function automatic int top_node();
		return (1 << (eff_levels() + 1)) - 1;
	endfunction

	function automatic bit is_free(int n);
		return !split_bits[n] && !used_bits[n];
	endfunction

	// Depth-first search, left child first; splits free nodes on the way down.
	function automatic int seek_block(int n, int lvl, int want);
		int got;
		if (n > top_node() || n >= bba_pkg::MapDepth) return 0;
		if (used_bits[n]) return 0;
		if (lvl == want) begin
			if (is_free(n)) begin
				used_bits[n] = 1'b1;
				return n;
			end
			return 0;
		end
		if (is_free(n)) split_bits[n] = 1'b1;
		if (!split_bits[n]) return 0;
		got = seek_block(2 * n, lvl + 1, want);
		if (got != 0) return got;
		return seek_block(2 * n + 1, lvl + 1, want);
	endfunction

	function automatic grant_t apply_item(logic op, logic [31:0] req, logic [11:0] idx);
		grant_t      g;
		logic [32:0] need;
		int          want;
		int          n;
		int          lvl;
		logic [63:0] prod;
		g.st = bba_pkg::ST_OK;
		g.node = '0;
		g.lvl = '0;
		g.offs = '0;
		if (op == bba_pkg::OpAlloc) begin
			need = {1'b0, req} + 33'(bba_pkg::HeaderBytes);
			if (req == 0) begin
				g.st = bba_pkg::ST_ZERO;
			end else if (need > {1'b0, arena_reg}) begin
				g.st = bba_pkg::ST_TOO_LARGE;
			end else begin
				want = eff_levels();
				while (want > 0 && {1'b0, arena_reg >> want} < need) want--;
				n = seek_block(1, 0, want);
				if (n == 0) begin
					g.st = bba_pkg::ST_NO_SPACE;
				end else begin
					lvl = $clog2(n + 1) - 1;
					prod = 64'(n - (1 << lvl)) * 64'(arena_reg >> lvl);
					g.node = 12'(n);
					g.lvl = 4'(lvl);
					g.offs = prod[31:0];
				end
			end
		end else begin
			if (idx == 0 || int'(idx) > top_node()) begin
				g.st = bba_pkg::ST_BAD_INDEX;
			end else if (!used_bits[idx]) begin
				g.st = bba_pkg::ST_NOT_USED;
			end else begin
				// Clear the node, then merge upward while both buddies are free.
				n = idx;
				used_bits[n] = 1'b0;
				while (n > 1) begin
					if (!is_free(n) || !is_free(n ^ 1)) break;
					split_bits[n >> 1] = 1'b0;
					n = n >> 1;
				end
			end
		end
		return g;
	endfunction

	// ------------------------------------------------------------------
	// Transfer tasks. Inputs change at the rising edge only; ready is
	// sampled on the falling edge where nothing moves.
	// ------------------------------------------------------------------
	task automatic send_item(logic op, logic [31:0] req, logic [11:0] idx);
		grant_t g;
		logic   took;
		int     k;
		in_valid      <= 1'b1;
		operation     <= op;
		request_bytes <= req;
		node_index    <= idx;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		g = apply_item(op, req, idx);
		grant_q.push_back(g);
		items_sent++;
		if (op == bba_pkg::OpAlloc && g.st == bba_pkg::ST_OK) held_nodes.push_back(g.node);
		if (op == bba_pkg::OpFree && g.st == bba_pkg::ST_OK) begin
			for (k = 0; k < held_nodes.size(); k++) begin
				if (held_nodes[k] == idx) begin
					held_nodes.delete(k);
					break;
				end
			end
		end
		// The sender runs in bursts; between bursts it usually lowers valid for a random gap.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers are only written with no transfer in flight.
	task automatic write_reg(logic which, logic [31:0] value);
		logic took;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		if (which == bba_pkg::CfgArena) arena_reg = value;
		else levels_reg = value[3:0];
		cfg_writes++;
		@(posedge clk);
	endtask

	// Request sized so that the chosen level is the deepest that fits, where a block there holds at least five bytes.
	function automatic logic [31:0] fit_request(int lvl);
		logic [31:0] blk;
		blk = arena_reg >> lvl;
		if (blk <= 5) return 32'd1;
		return blk - 32'd4 - $urandom_range(0, (blk > 40) ? 3 : 0);
	endfunction

	// ------------------------------------------------------------------
	// Result checker and receiver stall pattern.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_ready <= ($urandom_range(0, 4) == 0);
			end
		endcase
	end

	always @(negedge clk) begin
		grant_t g;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result, actual status %0d node %0d", $time,
					status, granted_node);
				errors++;
			end else begin
				g = grant_q.pop_front();
				if (status !== g.st) begin
					$display("%0t: status expected %0d actual %0d", $time, g.st, status);
					errors++;
				end
				if (granted_node !== g.node) begin
					$display("%0t: granted_node expected %0d actual %0d", $time, g.node,
						granted_node);
					errors++;
				end
				if (granted_level !== g.lvl) begin
					$display("%0t: granted_level expected %0d actual %0d", $time, g.lvl,
						granted_level);
					errors++;
				end
				if (byte_offset !== g.offs) begin
					$display("%0t: byte_offset expected %h actual %h", $time, g.offs,
						byte_offset);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Reset values: zero size, oversize, deepest fit, whole arena, bad and good frees.
	task automatic test_reset_defaults();
		send_item(bba_pkg::OpAlloc, 32'd0, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'hFFFF_FFFF, 12'hFFF);
		send_item(bba_pkg::OpAlloc, 32'hFFFF_FFFC, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpAlloc, bba_pkg::ArenaReset - 32'd4, 12'd0);
		send_item(bba_pkg::OpFree, 32'hFFFF_FFFF, 12'd0);
		send_item(bba_pkg::OpFree, 32'd0, 12'hFFF);
		send_item(bba_pkg::OpFree, 32'd0, 12'd3);
		send_item(bba_pkg::OpFree, 32'd0, 12'd256);
		send_item(bba_pkg::OpFree, 32'd0, 12'd256);
		send_item(bba_pkg::OpFree, 32'd0, 12'd257);
		// Tree is empty again, so the whole arena fits at the root.
		send_item(bba_pkg::OpAlloc, bba_pkg::ArenaReset - 32'd4, 12'd0);
		send_item(bba_pkg::OpFree, 32'd0, 12'd1);
	endtask

	// Arena sizes too small for a one-byte request and its header, and the smallest that works.
	task automatic test_tiny_arena();
		write_reg(bba_pkg::CfgArena, 32'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		write_reg(bba_pkg::CfgArena, 32'd4);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		write_reg(bba_pkg::CfgArena, 32'd5);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpFree, 32'd0, 12'd1);
	endtask

	// Level register out of range on both sides, plus a level-one tree filled up.
	task automatic test_level_limits();
		write_reg(bba_pkg::CfgArena, 32'hFFFF_FFFF);
		write_reg(bba_pkg::CfgLevels, 32'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpFree, 32'd0, 12'd4);
		send_item(bba_pkg::OpFree, 32'd0, 12'd2);
		send_item(bba_pkg::OpFree, 32'd0, 12'd3);
		write_reg(bba_pkg::CfgLevels, 32'd15);
		send_item(bba_pkg::OpAlloc, 32'd1, 12'd0);
		send_item(bba_pkg::OpFree, 32'd0, 12'd4095);
		send_item(bba_pkg::OpFree, 32'd0, 12'd2048);
	endtask

	// Random phases, each under its own register setting; held blocks carry over.
	task automatic test_random_traffic();
		int          phase;
		int          i;
		int          pick;
		int          count;
		logic [31:0] size_pick;
		for (phase = 0; phase < 16; phase++) begin
			case ($urandom_range(0, 4))
				0: size_pick = $urandom();
				1: size_pick = 32'h1 << $urandom_range(4, 31);
				2: size_pick = $urandom_range(1, 300);
				3: size_pick = 32'hFFFF_FFFF;
				default: size_pick = $urandom_range(4096, 1 << 24);
			endcase
			write_reg(bba_pkg::CfgArena, size_pick);
			if (phase == 7) write_reg(bba_pkg::CfgLevels, 32'd11);
			else if (phase == 12) write_reg(bba_pkg::CfgLevels, 32'd15);
			else write_reg(bba_pkg::CfgLevels, 32'($urandom_range(0, 6)));
			count = (levels_reg >= 11) ? 30 : 54;
			for (i = 0; i < count; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					send_item(bba_pkg::OpAlloc, fit_request($urandom_range(0, eff_levels())),
						12'd0);
				end else if (pick < 85 && held_nodes.size() != 0) begin
					send_item(bba_pkg::OpFree, $urandom(),
						held_nodes[$urandom_range(0, held_nodes.size() - 1)]);
				end else if (pick < 93) begin
					send_item(bba_pkg::OpFree, $urandom(), 12'($urandom_range(0, 4095)));
				end else begin
					send_item(bba_pkg::OpAlloc,
						($urandom_range(0, 1) != 0) ? $urandom() : 32'd0,
						12'($urandom_range(0, 4095)));
				end
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		operation     = 1'b0;
		request_bytes = '0;
		node_index    = '0;
		out_ready     = 1'b0;
		arena_reg     = bba_pkg::ArenaReset;
		levels_reg    = bba_pkg::LevelsReset;
		for (int i = 0; i < bba_pkg::MapDepth; i++) begin
			split_bits[i] = 1'b0;
			used_bits[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_tiny_arena();
		test_level_limits();
		test_random_traffic();

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d item transfers, %0d result transfers, %0d register writes.",
			items_sent, results_seen, cfg_writes);
		$display("Arena sizes from zero to full scale, level settings from 0 to 15.");
		if (errors == 0 && grant_q.size() == 0) begin
			$display("bitmap_buddy_allocator verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, grant_q.size());
			$display("bitmap_buddy_allocator verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/bba_pkg.sv
src/bba_datapath.sv
src/bba_ctrl.sv
src/bitmap_buddy_allocator.sv
tb/tb.sv
